// ===== rtl/cgl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_pkg: shared types and constants for the GLB chunk locator
// Header constants, byte classification codes, the queue entry that
// passes from front to back, and the result record.
// ----------------------------------------------------------------------------
package cgl_pkg;

	localparam logic [31:0] GLB_MAGIC    = 32'h4654_6C67;
	localparam logic [31:0] TYPE_JSON    = 32'h4E4F_534A;
	localparam logic [31:0] TYPE_BIN     = 32'h004E_4942;
	localparam logic [31:0] GLB_VERSION  = 32'd2;
	localparam logic [31:0] POS_MAGIC    = 32'd3;
	localparam logic [31:0] POS_VERSION  = 32'd7;
	localparam logic [31:0] POS_LENGTH   = 32'd11;
	localparam logic [31:0] HEADER_START = 32'd12;
	localparam logic [33:0] HEADER_BYTES = 34'd8;
	localparam logic [33:0] PAD_MASK     = 34'd3;

	// Byte count at which the first chunk header's type word completes
	localparam logic [33:0] FIRST_TYPE_AT = 34'd20;
	// Byte count at which the first chunk header's length word completes
	localparam logic [33:0] FIRST_LEN_AT  = 34'd16;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_EMPTY    = 3'd1,
		ERR_VERSION  = 3'd2,
		ERR_DECLARED = 3'd3,
		ERR_OVERRUN  = 3'd4,
		ERR_NO_JSON  = 3'd5
	} err_t;

	// Role of the byte that completes a word, by its file position
	typedef enum logic [2:0] {
		KIND_LEAD    = 3'd0,
		KIND_MAGIC   = 3'd1,
		KIND_VERSION = 3'd2,
		KIND_LENGTH  = 3'd3,
		KIND_BODY    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [31:0] count;     // bytes seen including this one, saturating
		logic [31:0] word;      // last four bytes, little-endian
		kind_t       kind;
		logic        has_byte;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic        container;
		logic [2:0]  error;
		logic [31:0] json_offset;
		logic [31:0] json_length;
		logic        bin_present;
		logic [31:0] bin_offset;
		logic [31:0] bin_length;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/cgl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_front: byte intake and classification
// Counts file bytes, assembles the little-endian word and tags each byte
// with its role in the container header before queueing it.
// ----------------------------------------------------------------------------
module cgl_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [7:0]     data_byte,
	input  wire logic           has_byte,
	input  wire logic           last,
	output logic                enq,
	output cgl_pkg::entry_t     enq_data
);

	logic [31:0] count_q;
	logic [31:0] word_q;
	logic [31:0] count_n;
	logic [31:0] word_n;
	cgl_pkg::kind_t kind;

	// Advance the saturating count and shift in the new byte
	always_comb begin
		count_n = (count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1;
		word_n  = {data_byte, word_q[31:8]};
	end

	// Classify the byte by its position before this byte
	always_comb begin
		priority if (!has_byte)                         kind = cgl_pkg::KIND_LEAD;
		else if (count_q == cgl_pkg::POS_MAGIC)         kind = cgl_pkg::KIND_MAGIC;
		else if (count_q == cgl_pkg::POS_VERSION)       kind = cgl_pkg::KIND_VERSION;
		else if (count_q == cgl_pkg::POS_LENGTH)        kind = cgl_pkg::KIND_LENGTH;
		else if (count_q >= cgl_pkg::HEADER_START)      kind = cgl_pkg::KIND_BODY;
		else                                            kind = cgl_pkg::KIND_LEAD;
	end

	// Queue real bytes and end markers; drop bare idle transactions
	always_comb begin
		enq               = take && (has_byte || last);
		enq_data.count    = has_byte ? count_n : count_q;
		enq_data.word     = word_n;
		enq_data.kind     = kind;
		enq_data.has_byte = has_byte;
		enq_data.last     = last;
	end

	// Hold position state; restart at end of file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			word_q  <= '0;
		end else if (take) begin
			if (last) begin
				count_q <= '0;
				word_q  <= '0;
			end else if (has_byte) begin
				count_q <= count_n;
				word_q  <= word_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cgl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_queue: short queue between front and back
// Register-based FIFO of classified bytes; lets either side stall alone.
// ----------------------------------------------------------------------------
module cgl_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            enq,
	input  wire cgl_pkg::entry_t enq_data,
	input  wire logic            deq,
	output logic                 full,
	output logic                 empty,
	output cgl_pkg::entry_t      head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	cgl_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign full  = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store incoming transactions
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_data;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			if (enq && !deq) begin
				fill_q <= fill_q + CW'(1);
			end else if (!enq && deq) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cgl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_back: header checks, chunk walk and result register
// Consumes one classified byte per cycle while the queue is not empty,
// holding an end of file until the previous result is popped; follows
// the chunk headers and forms the end-of-file result in a one-deep register.
module cgl_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire cgl_pkg::entry_t head,
	output logic                 deq,
	input  wire logic            pop,
	output logic                 out_valid,
	output cgl_pkg::result_t     result
);

	// Control state
	logic        magic_q, vbad_q, stop_q, ovr_q, jfound_q, bfound_q, out_valid_q;
	logic [33:0] type_at_q;   // count when the current header's type word completes
	logic [33:0] len_at_q;    // count when its length word completes
	// Payload state
	logic [31:0] decl_q, plen_q, room_q;
	logic [31:0] joff_q, jlen_q, boff_q, blen_q;
	logic [33:0] ntype_at_q, nlen_at_q;
	cgl_pkg::result_t out_q;

	// Next-state values
	logic        magic_n, vbad_n, stop_n, ovr_n, jfound_n, bfound_n;
	logic [31:0] decl_n, joff_n, jlen_n, boff_n, blen_n;
	logic [33:0] type_at_n, len_at_n;
	logic        walk, is_len, is_type, overrun;
	logic [33:0] count_w, rnd_len, chunk_end;
	cgl_pkg::result_t res;

	// Take a byte unless a result would have nowhere to go
	assign deq       = !q_empty && (!head.last || !out_valid_q || pop);
	assign out_valid = out_valid_q;
	assign result    = out_q;

	// Locate header words of the current chunk
	always_comb begin
		count_w   = {2'b00, head.count};
		walk      = head.has_byte && (head.kind == cgl_pkg::KIND_BODY) && magic_q &&
		            !stop_q && (type_at_q <= {2'b00, decl_q});
		is_len    = walk && (count_w == len_at_q);
		is_type   = walk && (count_w == type_at_q);
		overrun   = plen_q > room_q;
		rnd_len   = ({2'b00, head.word} + cgl_pkg::PAD_MASK) & ~cgl_pkg::PAD_MASK;
		chunk_end = type_at_q + rnd_len;
	end

	// Apply this byte to the container state
	always_comb begin
		magic_n   = magic_q;
		vbad_n    = vbad_q;
		decl_n    = decl_q;
		stop_n    = stop_q;
		ovr_n     = ovr_q;
		jfound_n  = jfound_q;
		bfound_n  = bfound_q;
		joff_n    = joff_q;
		jlen_n    = jlen_q;
		boff_n    = boff_q;
		blen_n    = blen_q;
		type_at_n = type_at_q;
		len_at_n  = len_at_q;
		if (head.has_byte) begin
			unique case (head.kind)
				cgl_pkg::KIND_MAGIC:   magic_n = (head.word == cgl_pkg::GLB_MAGIC);
				cgl_pkg::KIND_VERSION: vbad_n  = (head.word != cgl_pkg::GLB_VERSION);
				cgl_pkg::KIND_LENGTH:  decl_n  = head.word;
				default: ;
			endcase
		end
		if (is_type) begin
			if (overrun) begin
				ovr_n  = 1'b1;
				stop_n = 1'b1;
			end else begin
				if (head.word == cgl_pkg::TYPE_JSON && !jfound_q) begin
					jfound_n = 1'b1;
					joff_n   = type_at_q[31:0];
					jlen_n   = plen_q;
				end else if (head.word == cgl_pkg::TYPE_BIN && !bfound_q) begin
					bfound_n = 1'b1;
					boff_n   = type_at_q[31:0];
					blen_n   = plen_q;
				end
				type_at_n = ntype_at_q;
				len_at_n  = nlen_at_q;
			end
		end
	end

	// Form the end-of-file result; errors in check order
	always_comb begin
		res = '0;
		if (head.count == '0) begin
			res.error = cgl_pkg::ERR_EMPTY;
		end else if (head.count >= cgl_pkg::HEADER_START && magic_n) begin
			res.container = 1'b1;
			priority if (vbad_n)            res.error = cgl_pkg::ERR_VERSION;
			else if (decl_n > head.count)   res.error = cgl_pkg::ERR_DECLARED;
			else if (ovr_n)                 res.error = cgl_pkg::ERR_OVERRUN;
			else if (!jfound_n)             res.error = cgl_pkg::ERR_NO_JSON;
			else begin
				res.error       = cgl_pkg::ERR_OK;
				res.json_offset = joff_n;
				res.json_length = jlen_n;
				if (bfound_n) begin
					res.bin_present = 1'b1;
					res.bin_offset  = boff_n;
					res.bin_length  = blen_n;
				end
			end
		end else begin
			res.error       = cgl_pkg::ERR_OK;
			res.json_length = head.count;
		end
	end

	// Hold payload: header words, chunk bookkeeping, found places
	always_ff @(posedge clk) begin
		if (deq) begin
			decl_q <= decl_n;
			joff_q <= joff_n;
			jlen_q <= jlen_n;
			boff_q <= boff_n;
			blen_q <= blen_n;
			if (is_len) begin
				plen_q     <= head.word;
				room_q     <= decl_q - type_at_q[31:0];
				ntype_at_q <= chunk_end + cgl_pkg::HEADER_BYTES;
				nlen_at_q  <= chunk_end + (cgl_pkg::HEADER_BYTES - 34'd4);
			end
			if (head.last) begin
				out_q <= res;
			end
		end
	end

	// Advance control state; return to reset values after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= 1'b0;
			vbad_q      <= 1'b0;
			stop_q      <= 1'b0;
			ovr_q       <= 1'b0;
			jfound_q    <= 1'b0;
			bfound_q    <= 1'b0;
			type_at_q   <= cgl_pkg::FIRST_TYPE_AT;
			len_at_q    <= cgl_pkg::FIRST_LEN_AT;
			out_valid_q <= 1'b0;
		end else begin
			if (deq) begin
				if (head.last) begin
					magic_q   <= 1'b0;
					vbad_q    <= 1'b0;
					stop_q    <= 1'b0;
					ovr_q     <= 1'b0;
					jfound_q  <= 1'b0;
					bfound_q  <= 1'b0;
					type_at_q <= cgl_pkg::FIRST_TYPE_AT;
					len_at_q  <= cgl_pkg::FIRST_LEN_AT;
				end else begin
					magic_q   <= magic_n;
					vbad_q    <= vbad_n;
					stop_q    <= stop_n;
					ovr_q     <= ovr_n;
					jfound_q  <= jfound_n;
					bfound_q  <= bfound_n;
					type_at_q <= type_at_n;
					len_at_q  <= len_at_n;
				end
			end
			if (deq && head.last) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/glb_container_chunk_locator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glb_container_chunk_locator: GLB container and chunk locator
// Reads a model file byte by byte and reports at end of file whether it is
// a GLB container, any error, and where the JSON and BIN chunks lie.
// ----------------------------------------------------------------------------
// Usage
//   Input queue: drive data_byte/has_byte/last with push; a transaction is
//   taken on a clock edge with push high and full low. has_byte low with
//   last low is ignored; last high ends the file (with or without a byte).
//   Result queue: while empty is low the result ports hold the file's
//   result; pop high on a clock edge takes it.
//   Throughput: one byte per cycle, set by the back end, which consumes one
//   queued byte per cycle except while it holds an end of file (see Stall).
//   Result path: the front enqueues the end-of-file transaction on the
//   accepting edge; the back end then registers the result from the queue.
//   Stall: while a result waits, the back end keeps consuming bytes of the
//   next file; it holds at the next end of file until the result is popped,
//   and full rises once the QUEUE_DEPTH-entry queue fills behind it.
//   Reset: arst_n clears queue pointers, result valid flag, front count, back
//   control state; no clearing pass follows, bytes go in on the first cycle.
// ----------------------------------------------------------------------------
module glb_container_chunk_locator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic             container,
	output logic [2:0]       error,
	output logic [31:0]      json_offset,
	output logic [31:0]      json_length,
	output logic             bin_present,
	output logic [31:0]      bin_offset,
	output logic [31:0]      bin_length
);

	logic             take;
	logic             enq;
	logic             deq;
	logic             q_empty;
	logic             out_valid;
	cgl_pkg::entry_t  enq_data;
	cgl_pkg::entry_t  head;
	cgl_pkg::result_t result;

	assign take = push && !full;

	// Front: count, assemble and classify bytes
	cgl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.enq       (enq),
		.enq_data  (enq_data)
	);

	// Queue between front and back
	cgl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_data (enq_data),
		.deq      (deq),
		.full     (full),
		.empty    (q_empty),
		.head     (head)
	);

	// Back: header checks, chunk walk, result register
	cgl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.deq       (deq),
		.pop       (pop),
		.out_valid (out_valid),
		.result    (result)
	);

	// Present the waiting result
	assign empty       = !out_valid;
	assign container   = result.container;
	assign error       = result.error;
	assign json_offset = result.json_offset;
	assign json_length = result.json_length;
	assign bin_present = result.bin_present;
	assign bin_offset  = result.bin_offset;
	assign bin_length  = result.bin_length;

endmodule
`default_nettype wire

// ===== rtl/cgl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_checker: port-level checks for the GLB chunk locator
// Watches the result queue and the consistency of reported fields.
// ----------------------------------------------------------------------------
module cgl_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic        container,
	input  wire logic [2:0]  error,
	input  wire logic [31:0] json_offset,
	input  wire logic [31:0] json_length,
	input  wire logic        bin_present,
	input  wire logic [31:0] bin_offset,
	input  wire logic [31:0] bin_length
);

	// Error code stays within the defined set
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (error <= cgl_pkg::ERR_NO_JSON))
		else $error("error code out of range");

	// A failing file reports no chunk places
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error != cgl_pkg::ERR_OK) |->
		(json_offset == '0 && json_length == '0 && !bin_present &&
		 bin_offset == '0 && bin_length == '0))
		else $error("chunk fields set on an error result");

	// Plain text starts at zero and has no binary chunk; only OK or empty-file errors
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !container) |->
		(json_offset == '0 && !bin_present && error != cgl_pkg::ERR_VERSION &&
		 error != cgl_pkg::ERR_DECLARED && error != cgl_pkg::ERR_OVERRUN &&
		 error != cgl_pkg::ERR_NO_JSON))
		else $error("plain text result inconsistent");

	// A waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(error) && $stable(container) &&
		 $stable(json_length) && $stable(bin_length)))
		else $error("waiting result changed");

endmodule

bind glb_container_chunk_locator cgl_checker u_cgl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.container   (container),
	.error       (error),
	.json_offset (json_offset),
	.json_length (json_length),
	.bin_present (bin_present),
	.bin_offset  (bin_offset),
	.bin_length  (bin_length)
);
`default_nettype wire

// ===== tb/tb_glb_container_chunk_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glb_container_chunk_locator: self-checking bench for the GLB locator
// Streams plain JSON text and GLB containers, valid and broken, one byte per
// transaction. A built-in locator model predicts the end-of-file report. Each
// popped result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_glb_container_chunk_locator;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int ITEM_GOAL     = 1750;
	localparam int MAX_REPORTS   = 10;
	localparam int MAX_CHUNKS    = 4;
	// offsets of the final byte of each chunk header word
	localparam logic [63:0] LEN_WORD_END  = 64'd3;
	localparam logic [63:0] TYPE_WORD_END = 64'd7;
	localparam logic [31:0] POS_SATURATED = 32'hFFFF_FFFF;
	localparam logic [31:0] TYPE_OTHER    = 32'h5845_5400;

	typedef enum int {
		FAULT_NONE,
		FAULT_VERSION,
		FAULT_DECL_OVER,
		FAULT_DECL_UNDER,
		FAULT_OVERRUN,
		FAULT_NO_JSON,
		FAULT_TRAIL,
		FAULT_CUT
	} glb_fault_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last;
	logic        empty;
	logic        pop;
	logic        container;
	logic [2:0]  error;
	logic [31:0] json_offset;
	logic [31:0] json_length;
	logic        bin_present;
	logic [31:0] bin_offset;
	logic [31:0] bin_length;

	// locator model state
	logic [31:0] loc_pos;
	logic [31:0] loc_shift;
	logic        loc_magic;
	logic        loc_ver_bad;
	logic [31:0] loc_declared;
	logic [63:0] loc_next_hdr;
	logic [31:0] loc_chunk_len;
	logic        loc_stopped;
	logic        loc_overrun;
	logic        loc_json_found;
	logic [31:0] loc_json_off;
	logic [31:0] loc_json_len;
	logic        loc_bin_found;
	logic [31:0] loc_bin_off;
	logic [31:0] loc_bin_len;

	cgl_pkg::result_t expected_reports[$];
	logic [7:0]  file_q[$];
	logic [31:0] ck_type[MAX_CHUNKS];
	logic [31:0] ck_field[MAX_CHUNKS];
	int          ck_len[MAX_CHUNKS];
	int          n_ck;
	int          fail_count = 0;
	int          item_count = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;

	glb_container_chunk_locator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.has_byte    (has_byte),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.container   (container),
		.error       (error),
		.json_offset (json_offset),
		.json_length (json_length),
		.bin_present (bin_present),
		.bin_offset  (bin_offset),
		.bin_length  (bin_length)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Locator model
	// ------------------------------------------------------------------
	function automatic void loc_clear();
		loc_pos        = '0;
		loc_shift      = '0;
		loc_magic      = 1'b0;
		loc_ver_bad    = 1'b0;
		loc_declared   = '0;
		loc_next_hdr   = {32'd0, cgl_pkg::HEADER_START};
		loc_chunk_len  = '0;
		loc_stopped    = 1'b0;
		loc_overrun    = 1'b0;
		loc_json_found = 1'b0;
		loc_json_off   = '0;
		loc_json_len   = '0;
		loc_bin_found  = 1'b0;
		loc_bin_off    = '0;
		loc_bin_len    = '0;
	endfunction

	// Close a chunk header: stop the walk on overrun, else record and skip data
	function automatic void loc_take_type(input logic [31:0] kind_word);
		logic [63:0] at;
		logic [63:0] len;
		at  = loc_next_hdr + {30'd0, cgl_pkg::HEADER_BYTES};
		len = {32'd0, loc_chunk_len};
		if (len > {32'd0, loc_declared} - at) begin
			loc_overrun = 1'b1;
			loc_stopped = 1'b1;
			return;
		end
		if (kind_word == cgl_pkg::TYPE_JSON && !loc_json_found) begin
			loc_json_found = 1'b1;
			loc_json_off   = at[31:0];
			loc_json_len   = len[31:0];
		end else if (kind_word == cgl_pkg::TYPE_BIN && !loc_bin_found) begin
			loc_bin_found = 1'b1;
			loc_bin_off   = at[31:0];
			loc_bin_len   = len[31:0];
		end
		loc_next_hdr = at + ((len + {30'd0, cgl_pkg::PAD_MASK}) &
			~{30'd0, cgl_pkg::PAD_MASK});
	endfunction

	function automatic void loc_take_byte(input logic [7:0] b);
		logic [63:0] p;
		p = {32'd0, loc_pos};
		loc_shift = {b, loc_shift[31:8]};
		if (loc_pos == cgl_pkg::POS_MAGIC)   loc_magic    = (loc_shift == cgl_pkg::GLB_MAGIC);
		if (loc_pos == cgl_pkg::POS_VERSION) loc_ver_bad  = (loc_shift != cgl_pkg::GLB_VERSION);
		if (loc_pos == cgl_pkg::POS_LENGTH)  loc_declared = loc_shift;
		if (loc_pos >= cgl_pkg::HEADER_START && loc_magic && !loc_stopped &&
				loc_next_hdr + {30'd0, cgl_pkg::HEADER_BYTES} <= {32'd0, loc_declared}) begin
			if (p == loc_next_hdr + LEN_WORD_END)
				loc_chunk_len = loc_shift;
			else if (p == loc_next_hdr + TYPE_WORD_END)
				loc_take_type(loc_shift);
		end
		if (loc_pos != POS_SATURATED) loc_pos = loc_pos + 32'd1;
	endfunction

	// Advance the model by one transaction; return 1 with the report at end of file
	function automatic bit loc_accept(input logic [7:0] b, input logic hb, input logic lst,
			output cgl_pkg::result_t rpt);
		rpt = '0;
		if (hb) loc_take_byte(b);
		if (!lst) return 1'b0;
		if (loc_pos == 32'd0) begin
			rpt.error = cgl_pkg::ERR_EMPTY;
		end else if (loc_pos >= cgl_pkg::HEADER_START && loc_magic) begin
			rpt.container = 1'b1;
			if (loc_ver_bad)                 rpt.error = cgl_pkg::ERR_VERSION;
			else if (loc_declared > loc_pos) rpt.error = cgl_pkg::ERR_DECLARED;
			else if (loc_overrun)            rpt.error = cgl_pkg::ERR_OVERRUN;
			else if (!loc_json_found)        rpt.error = cgl_pkg::ERR_NO_JSON;
			else begin
				rpt.error       = cgl_pkg::ERR_OK;
				rpt.json_offset = loc_json_off;
				rpt.json_length = loc_json_len;
				if (loc_bin_found) begin
					rpt.bin_present = 1'b1;
					rpt.bin_offset  = loc_bin_off;
					rpt.bin_length  = loc_bin_len;
				end
			end
		end else begin
			rpt.json_length = loc_pos;
		end
		loc_clear();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Send one transaction; entered and left at a falling edge
	task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
		int               gap;
		cgl_pkg::result_t rpt;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		has_byte  <= hb;
		last      <= lst;
		do @(posedge clk); while (full);
		if (loc_accept(b, hb, lst, rpt))
			expected_reports.insert(expected_reports.size(), rpt);
		item_count++;
		@(negedge clk);
	endtask

	// Stream file_q, optionally with ignored bare transactions and a bare end marker
	task automatic send_file(input bit bare_end, input bit noisy);
		int n;
		n = file_q.size();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(file_q[i], 1'b1, (i == n - 1) && !bare_end);
		end
		if (bare_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	function automatic void put_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endfunction

	function automatic void put_word(input logic [31:0] w);
		put_byte(w[7:0]);
		put_byte(w[15:8]);
		put_byte(w[23:16]);
		put_byte(w[31:24]);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) put_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic int padded(input int n);
		return (n + 3) & ~3;
	endfunction

	function automatic int glb_total();
		int t;
		t = int'(cgl_pkg::HEADER_START);
		for (int i = 0; i < n_ck; i++)
			t += int'(cgl_pkg::HEADER_BYTES) + padded(ck_len[i]);
		return t;
	endfunction

	// Build a container from the chunk table; pad bytes are random
	function automatic void emit_glb(input logic [31:0] ver, input logic [31:0] declared);
		file_q.delete();
		put_word(cgl_pkg::GLB_MAGIC);
		put_word(ver);
		put_word(declared);
		for (int i = 0; i < n_ck; i++) begin
			put_word(ck_field[i]);
			put_word(ck_type[i]);
			put_random(padded(ck_len[i]));
		end
	endfunction

	function automatic void set_chunk(input int i, input logic [31:0] kind_word, input int len);
		ck_type[i]  = kind_word;
		ck_len[i]   = len;
		ck_field[i] = len;
	endfunction

	// Random container, mostly well formed, with an optional injected fault
	function automatic void make_glb(input glb_fault_t fault);
		int          total;
		int          k;
		int          pick;
		logic [31:0] ver;
		logic [31:0] declared;
		n_ck = $urandom_range(fault == FAULT_OVERRUN ? 1 : 0, MAX_CHUNKS);
		for (int i = 0; i < n_ck; i++) begin
			pick = $urandom_range(0, 9);
			set_chunk(i, pick < 4 ? cgl_pkg::TYPE_JSON :
				pick < 7 ? cgl_pkg::TYPE_BIN : $urandom,
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
			if (fault == FAULT_NO_JSON && ck_type[i] == cgl_pkg::TYPE_JSON)
				ck_type[i] = cgl_pkg::TYPE_BIN;
		end
		if (fault != FAULT_NO_JSON && n_ck > 0 && $urandom_range(0, 3) != 0)
			ck_type[0] = cgl_pkg::TYPE_JSON;
		total = glb_total();
		if (fault == FAULT_OVERRUN) begin
			k = $urandom_range(0, n_ck - 1);
			ck_field[k] = $urandom_range(0, 1) ? POS_SATURATED : total + $urandom_range(0, 4);
		end
		ver = cgl_pkg::GLB_VERSION;
		if (fault == FAULT_VERSION) begin
			ver = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
			if (ver == cgl_pkg::GLB_VERSION) ver = '0;
		end
		declared = total;
		if (fault == FAULT_DECL_OVER)
			declared = $urandom_range(0, 1) ? total + $urandom_range(1, 8) : POS_SATURATED;
		else if (fault == FAULT_DECL_UNDER)
			declared = $urandom_range(0, total - 1);
		emit_glb(ver, declared);
		if (fault == FAULT_TRAIL) put_random($urandom_range(1, 6));
		if (fault == FAULT_CUT) repeat ($urandom_range(1, 6)) void'(file_q.pop_back());
	endfunction

	// ------------------------------------------------------------------
	// Result side: pop with random stalls and check against the model
	// ------------------------------------------------------------------
	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
	endtask

	initial begin
		cgl_pkg::result_t got;
		cgl_pkg::result_t want;
		int               stall;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.container   = container;
			got.error       = error;
			got.json_offset = json_offset;
			got.json_length = json_length;
			got.bin_present = bin_present;
			got.bin_offset  = bin_offset;
			got.bin_length  = bin_length;
			if (expected_reports.size() == 0) begin
				note_failure("result popped with none expected");
			end else begin
				want = expected_reports.pop_front();
				if (got.container !== want.container || got.error !== want.error ||
						got.json_offset !== want.json_offset ||
						got.json_length !== want.json_length ||
						got.bin_present !== want.bin_present ||
						got.bin_offset !== want.bin_offset ||
						got.bin_length !== want.bin_length)
					note_failure($sformatf({"report differs: exp c=%0d e=%0d j=%0h+%0h b=%0d %0h+%0h",
						" got c=%0d e=%0d j=%0h+%0h b=%0d %0h+%0h"},
						want.container, want.error, want.json_offset, want.json_length,
						want.bin_present, want.bin_offset, want.bin_length,
						got.container, got.error, got.json_offset, got.json_length,
						got.bin_present, got.bin_offset, got.bin_length));
			end
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Empty file, one-byte files with both end styles, ignored bare transactions, a text file
	task automatic test_empty_and_tiny();
		file_q.delete();
		send_file(1'b1, 1'b0);
		file_q = '{8'hFF};
		send_file(1'b0, 1'b0);
		file_q = '{8'h00};
		send_file(1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		file_q = '{8'h7B, 8'h7D, 8'h0A};
		send_file(1'b0, 1'b0);
	endtask

	// Text files, including a magic too short to count as a container
	task automatic test_plain_json();
		file_q.delete();
		put_word(cgl_pkg::GLB_MAGIC);
		put_random(3);
		send_file(1'b0, 1'b0);
		file_q.delete();
		put_word(cgl_pkg::GLB_MAGIC ^ 32'h0000_0001);
		put_word(cgl_pkg::GLB_VERSION);
		put_word(32'd12);
		send_file(1'b1, 1'b0);
	endtask

	// Well-formed containers: odd lengths, unknown types, repeats, trailing bytes
	task automatic test_glb_valid();
		n_ck = 4;
		set_chunk(0, cgl_pkg::TYPE_JSON, 5);
		set_chunk(1, TYPE_OTHER, 3);
		set_chunk(2, cgl_pkg::TYPE_BIN, 8);
		set_chunk(3, cgl_pkg::TYPE_JSON, 4);
		emit_glb(cgl_pkg::GLB_VERSION, glb_total());
		send_file(1'b1, 1'b0);
		n_ck = 3;
		set_chunk(0, cgl_pkg::TYPE_BIN, 0);
		set_chunk(1, cgl_pkg::TYPE_BIN, 2);
		set_chunk(2, cgl_pkg::TYPE_JSON, 1);
		emit_glb(cgl_pkg::GLB_VERSION, glb_total());
		put_random(5);
		send_file(1'b0, 1'b1);
	endtask

	// One container per container error: version, declared length, overrun, no JSON
	task automatic test_glb_errors();
		n_ck = 1;
		set_chunk(0, cgl_pkg::TYPE_JSON, 4);
		emit_glb(32'hFFFF_FFFF, glb_total());
		send_file(1'b0, 1'b0);
		emit_glb(cgl_pkg::GLB_VERSION, POS_SATURATED);
		send_file(1'b0, 1'b0);
		ck_field[0] = POS_SATURATED;
		emit_glb(cgl_pkg::GLB_VERSION, glb_total());
		send_file(1'b0, 1'b0);
		n_ck = 0;
		emit_glb(cgl_pkg::GLB_VERSION, cgl_pkg::HEADER_START);
		send_file(1'b0, 1'b0);
	endtask

	// Random files until the whole run has sent enough transactions
	task automatic test_random_files();
		int         pick;
		glb_fault_t fault;
		while (item_count < ITEM_GOAL) begin
			quiet = ($urandom_range(0, 7) == 0);
			pick  = $urandom_range(0, 19);
			file_q.delete();
			if (pick < 14) begin
				pick  = $urandom_range(0, 15);
				fault = (pick >= 8 && pick <= 14) ? glb_fault_t'(pick - 7) : FAULT_NONE;
				make_glb(fault);
			end else if (pick < 17) begin
				put_random($urandom_range(1, 40));
			end else if (pick < 19) begin
				put_word(cgl_pkg::GLB_MAGIC);
				put_random($urandom_range(0, 7));
			end
			send_file($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		end
		quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		data_byte = '0;
		has_byte  = 1'b0;
		last      = 1'b0;
		loc_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_and_tiny();
		test_plain_json();
		test_glb_valid();
		test_glb_errors();
		test_random_files();

		// drop push, drain the outstanding reports, then let the pipe settle
		push <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("glb_container_chunk_locator: match");
		else
			$display("glb_container_chunk_locator: mismatch");
		$finish;
	end

	// Watchdog: end the run if it hangs
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout with %0d reports outstanding", expected_reports.size());
		$display("glb_container_chunk_locator: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cgl_pkg.sv
rtl/cgl_front.sv
rtl/cgl_queue.sv
rtl/cgl_back.sv
rtl/glb_container_chunk_locator.sv
rtl/cgl_checker.sv
tb/tb_glb_container_chunk_locator.sv
